// ----- hdl/udp_tx_checksum_generator_unit_defines.svh -----
// assertion macros for the udp transmit checksum block
`ifndef UDP_TX_CHECKSUM_GENERATOR_UNIT_DEFINES_SVH
`define UDP_TX_CHECKSUM_GENERATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define UTC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define UTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define UTC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define UTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/udp_tx_ck_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package udp_tx_ck_pkg;

  localparam int MAX_PAYLOAD      = 1472;
  localparam int UDP_HEADER_BYTES = 8;
  localparam int LEN_W            = $clog2(MAX_PAYLOAD + UDP_HEADER_BYTES + 1);

  localparam logic [15:0] UDP_PROTOCOL     = 16'h0011;
  localparam logic [15:0] NO_CHECKSUM_CODE = 16'hFFFF;

  typedef logic [LEN_W-1:0] len_t;

  // item held in the input register, header words already summed
  typedef struct packed {
    logic        first;
    logic        last;
    logic        byte_valid;
    logic [7:0]  data_byte;
    logic [15:0] hdr_sum;
    len_t        limit;
  } stage_item_t;

  // datagram handed over for the final fold
  typedef struct packed {
    logic [15:0] sum;
    logic [7:0]  pend;
    logic        odd;
    len_t        seglen;
  } finish_t;

  // ones-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/udp_tx_ck_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface udp_tx_ck_item_if;
  logic        valid;
  logic        ready;
  logic        first;
  logic        last;
  logic [31:0] dst_ip;
  logic [15:0] local_port;
  logic [15:0] dst_port;
  logic [15:0] payload_len;
  logic        byte_valid;
  logic [7:0]  data_byte;

  modport source (
    output valid, first, last, dst_ip, local_port, dst_port, payload_len, byte_valid,
           data_byte,
    input  ready
  );
  modport sink (
    input  valid, first, last, dst_ip, local_port, dst_port, payload_len, byte_valid,
           data_byte,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/udp_tx_ck_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface udp_tx_ck_result_if;
  logic                        valid;
  logic                        ready;
  logic [15:0]                 checksum;
  logic [udp_tx_ck_pkg::LEN_W-1:0] segment_length;

  modport source (
    output valid, checksum, segment_length,
    input  ready
  );
  modport sink (
    input  valid, checksum, segment_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/udp_tx_ck_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface udp_tx_ck_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] local_ip;

  modport source (
    output valid, local_ip,
    input  ready
  );
  modport sink (
    input  valid, local_ip,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/udp_tx_ck_hdr.sv -----
`timescale 1ns / 1ps
`default_nettype none

module udp_tx_ck_hdr (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [31:0]                local_ip,
  udp_tx_ck_item_if.sink                  item,
  input  wire logic                       a_go,
  output udp_tx_ck_pkg::stage_item_t      a_item,
  output logic                            a_valid
);

  logic [18:0]                wide_sum;
  logic [16:0]                fold1;
  logic [15:0]                hdr_fold;
  udp_tx_ck_pkg::len_t        limit;
  logic                       take_req;

  // header words added as plain integers, then folded twice
  assign wide_sum = {3'd0, local_ip[31:16]} + {3'd0, local_ip[15:0]}
                  + {3'd0, item.dst_ip[31:16]} + {3'd0, item.dst_ip[15:0]}
                  + {3'd0, udp_tx_ck_pkg::UDP_PROTOCOL}
                  + {3'd0, item.local_port} + {3'd0, item.dst_port};
  assign fold1    = {1'b0, wide_sum[15:0]} + {14'd0, wide_sum[18:16]};
  assign hdr_fold = fold1[15:0] + {15'd0, fold1[16]};

  assign limit = (item.payload_len > 16'(udp_tx_ck_pkg::MAX_PAYLOAD))
               ? udp_tx_ck_pkg::LEN_W'(udp_tx_ck_pkg::MAX_PAYLOAD)
               : item.payload_len[udp_tx_ck_pkg::LEN_W-1:0];

  assign item.ready = !a_valid || a_go;
  assign take_req   = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take_req) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_req) begin
      a_item.first      <= item.first;
      a_item.last       <= item.last;
      a_item.byte_valid <= item.byte_valid;
      a_item.data_byte  <= item.data_byte;
      a_item.hdr_sum    <= hdr_fold;
      a_item.limit      <= limit;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/udp_tx_ck_acc.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "udp_tx_checksum_generator_unit_defines.svh"

module udp_tx_ck_acc (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire udp_tx_ck_pkg::stage_item_t a_item,
  input  wire logic                       a_valid,
  output logic                            a_go,
  input  wire logic                       c_ready,
  output udp_tx_ck_pkg::finish_t          c_item,
  output logic                            c_valid
);

  logic [15:0]         running_sum;
  udp_tx_ck_pkg::len_t bytes_taken;
  udp_tx_ck_pkg::len_t byte_limit;
  logic [7:0]          pending_high;
  logic                odd_pending;

  logic [15:0]         base_sum;
  udp_tx_ck_pkg::len_t base_taken;
  udp_tx_ck_pkg::len_t base_limit;
  logic [7:0]          base_pend;
  logic                base_odd;
  logic                take;
  logic [15:0]         running_sum_next;
  udp_tx_ck_pkg::len_t bytes_taken_next;
  logic [7:0]          pending_high_next;
  logic                odd_pending_next;

  // a first item restarts the datagram before its own byte is counted
  always_comb begin
    base_sum   = a_item.first ? a_item.hdr_sum : running_sum;
    base_taken = a_item.first ? '0 : bytes_taken;
    base_limit = a_item.first ? a_item.limit : byte_limit;
    base_pend  = a_item.first ? 8'd0 : pending_high;
    base_odd   = a_item.first ? 1'b0 : odd_pending;

    take = a_item.byte_valid && (base_taken < base_limit);

    running_sum_next  = (take && base_odd)
                      ? udp_tx_ck_pkg::oc_add(base_sum, {base_pend, a_item.data_byte})
                      : base_sum;
    pending_high_next = (take && !base_odd) ? a_item.data_byte : base_pend;
    odd_pending_next  = take ? !base_odd : base_odd;
    bytes_taken_next  = base_taken + udp_tx_ck_pkg::LEN_W'(take);
  end

  // a last item needs the hand-over register free or draining
  assign a_go = a_valid && (!a_item.last || !c_valid || c_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      bytes_taken  <= '0;
      byte_limit   <= '0;
      pending_high <= '0;
      odd_pending  <= 1'b0;
    end else if (a_go) begin
      if (a_item.last) begin
        running_sum  <= '0;
        bytes_taken  <= '0;
        byte_limit   <= '0;
        pending_high <= '0;
        odd_pending  <= 1'b0;
      end else begin
        running_sum  <= running_sum_next;
        bytes_taken  <= bytes_taken_next;
        byte_limit   <= base_limit;
        pending_high <= pending_high_next;
        odd_pending  <= odd_pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (a_go && a_item.last) begin
      c_valid <= 1'b1;
    end else if (c_ready) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_item.last) begin
      c_item.sum    <= running_sum_next;
      c_item.pend   <= pending_high_next;
      c_item.odd    <= odd_pending_next;
      c_item.seglen <= udp_tx_ck_pkg::LEN_W'(udp_tx_ck_pkg::UDP_HEADER_BYTES)
                     + bytes_taken_next;
    end
  end

  `UTC_ASSERT_IMPL(a_taken_bound, clk, rst, 1'b1, bytes_taken <= byte_limit, "byte count past limit")
  `UTC_ASSERT_IMPL(a_odd_parity, clk, rst, 1'b1, odd_pending == bytes_taken[0], "odd flag out of step with count")
  `UTC_ASSERT_NEXT(a_last_handover, clk, rst, a_go && a_item.last, c_valid, "last request not handed over")

endmodule

`default_nettype wire

// ----- hdl/udp_tx_ck_fin.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "udp_tx_checksum_generator_unit_defines.svh"

module udp_tx_ck_fin (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire udp_tx_ck_pkg::finish_t  c_item,
  input  wire logic                    c_valid,
  output logic                         c_ready,
  udp_tx_ck_result_if.source           result
);

  logic [17:0] total;
  logic [16:0] fold1;
  logic [15:0] folded;
  logic [15:0] csum;
  logic        load;

  // length counted twice: pseudo-header and udp header
  assign total  = {2'd0, c_item.sum}
                + (c_item.odd ? {2'd0, c_item.pend, 8'd0} : 18'd0)
                + 18'({c_item.seglen, 1'b0});
  assign fold1  = {1'b0, total[15:0]} + {15'd0, total[17:16]};
  assign folded = fold1[15:0] + {15'd0, fold1[16]};
  assign csum   = (~folded == 16'd0) ? udp_tx_ck_pkg::NO_CHECKSUM_CODE : ~folded;

  assign c_ready = !result.valid || result.ready;
  assign load    = c_valid && c_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.checksum       <= csum;
      result.segment_length <= c_item.seglen;
    end
  end

  `UTC_ASSERT_NEXT(a_fin_load, clk, rst, load, result.valid, "hand-over lost")
  `UTC_ASSERT_IMPL(a_fin_length, clk, rst, result.valid, result.segment_length >= udp_tx_ck_pkg::LEN_W'(udp_tx_ck_pkg::UDP_HEADER_BYTES), "segment shorter than header")

endmodule

`default_nettype wire

// ----- hdl/udp_tx_checksum_generator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// UDP transmit checksum over the IPv4 pseudo-header, the UDP header and the
// payload. One request is taken every cycle while the output does not stall a
// datagram's last request. A result (checksum with zero sent as 0xFFFF, and
// segment length) is built in order: the request is registered, the running
// sum and the hand-over register are updated from it, and the fold and
// complement are loaded into the output register. The update of the running
// ones-complement sum is what paces the block at one byte a cycle.
// local_ip is to be written through cfg only while no datagram is in flight;
// the block does not enforce this. Reset clears it to zero along with the
// datagram state.
module udp_tx_checksum_generator_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  udp_tx_ck_cfg_if.sink      cfg,
  udp_tx_ck_item_if.sink     item,
  udp_tx_ck_result_if.source result
);

  logic [31:0]                local_ip;
  udp_tx_ck_pkg::stage_item_t a_item;
  logic                       a_valid;
  logic                       a_go;
  udp_tx_ck_pkg::finish_t     c_item;
  logic                       c_valid;
  logic                       c_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
    end else if (cfg.valid && cfg.ready) begin
      local_ip <= cfg.local_ip;
    end
  end

  udp_tx_ck_hdr u_hdr (
    .clk      (clk),
    .rst      (rst),
    .local_ip (local_ip),
    .item     (item),
    .a_go     (a_go),
    .a_item   (a_item),
    .a_valid  (a_valid)
  );

  udp_tx_ck_acc u_acc (
    .clk     (clk),
    .rst     (rst),
    .a_item  (a_item),
    .a_valid (a_valid),
    .a_go    (a_go),
    .c_ready (c_ready),
    .c_item  (c_item),
    .c_valid (c_valid)
  );

  udp_tx_ck_fin u_fin (
    .clk     (clk),
    .rst     (rst),
    .c_item  (c_item),
    .c_valid (c_valid),
    .c_ready (c_ready),
    .result  (result)
  );

endmodule

`default_nettype wire
